// ===== design/osm_pkg.sv =====
// Shared types, constants and mapping functions of the OFDM symbol mapper.
`default_nettype none
package osm_pkg;

    localparam int VAL_W       = 17;
    localparam int POS_W       = 4;
    localparam int STREAM_W    = 2;
    localparam int PAYLOAD_W   = 6;
    localparam int MOD_W       = 2;
    localparam int BITS_W      = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_STREAM0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_STREAM1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_STREAM2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_STREAM3 = 3'd3;

    // Modulation codes; the unused code maps as 16QAM
    localparam logic [MOD_W-1:0] MOD_BPSK  = 2'd0;
    localparam logic [MOD_W-1:0] MOD_QPSK  = 2'd1;
    localparam logic [MOD_W-1:0] MOD_QAM16 = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST     = 4'd13;
    localparam logic [POS_W-1:0] SC_PILOT_LO  = 4'd0;
    localparam logic [POS_W-1:0] SC_PILOT_HI  = 4'd15;

    localparam logic signed [VAL_W-1:0] ONE_Q15  = 17'sd32768;
    localparam logic signed [VAL_W-1:0] QPSK_MAG = 17'sd23170;

    // PN sequence, bit i set where the sign of payload symbol i is -1
    localparam logic [63:0] PN_NEG = 64'h9836_BA32_2049_A7B8;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t re;
        val_t im;
    } point_t;

    // One classified input item
    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [MOD_W-1:0]    mode;
        logic [BITS_W-1:0]   bits;
        logic [POS_W-1:0]    pos;
        logic                first;
        logic                final_pos;
        logic                pn_neg;
        logic                frame_end;
    } cmd_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [POS_W-1:0]    subcarrier;
        val_t                re;
        val_t                im;
        logic                is_pilot;
        logic                frame_end;
        logic                last;
    } result_t;

    function automatic val_t qam_level(input logic [1:0] code);
        val_t v;
        case (code)
            2'd0:    v = -17'sd31088;
            2'd1:    v = -17'sd10362;
            2'd2:    v = 17'sd31087;
            default: v = 17'sd10361;
        endcase
        return v;
    endfunction

    function automatic point_t map_data(input logic [MOD_W-1:0] mode,
                                        input logic [BITS_W-1:0] bits);
        point_t p;
        case (mode)
            MOD_BPSK:
            begin
                p.re = bits[0] ? ONE_Q15 : -ONE_Q15;
                p.im = '0;
            end
            MOD_QPSK:
            begin
                p.re = bits[1] ? QPSK_MAG : -QPSK_MAG;
                p.im = bits[0] ? QPSK_MAG : -QPSK_MAG;
            end
            default:
            begin
                p.re = qam_level(bits[3:2]);
                p.im = qam_level(bits[1:0]);
            end
        endcase
        return p;
    endfunction

    // Streams 0,1 have a negative real part, streams 1,3 a negative imaginary part; pn_neg inverts both
    function automatic point_t pilot_point(input logic [STREAM_W-1:0] stream,
                                           input logic pn_neg);
        point_t p;
        p.re = ((~stream[1]) ^ pn_neg) ? -QPSK_MAG : QPSK_MAG;
        p.im = (stream[0] ^ pn_neg) ? -QPSK_MAG : QPSK_MAG;
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== design/osm_front.sv =====
// Front end: configuration registers, frame counters and item classification.
`default_nettype none
module osm_front #(
    parameter int PAYLOAD_SYMBOLS = 16,
    parameter int STREAMS         = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [osm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [osm_pkg::MOD_W-1:0]          cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [osm_pkg::BITS_W-1:0]         in_bits,
    input  wire logic                               q_full,
    output logic                                    push,
    output osm_pkg::cmd_t                           cmd
);
    import osm_pkg::*;

    localparam logic [STREAM_W-1:0]  STREAM_LAST  = STREAM_W'(STREAMS - 1);
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_LAST = PAYLOAD_W'(PAYLOAD_SYMBOLS - 1);

    logic [MOD_W-1:0]     mod_reg [4];
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [STREAM_W-1:0]  stream_reg, stream_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 final_pos;
    logic                 stream_wrap;
    logic                 payload_wrap;

    assign in_ready     = !q_full;
    assign push         = in_valid && !q_full;
    assign final_pos    = pos_reg >= POS_LAST;
    assign stream_wrap  = stream_reg >= STREAM_LAST;
    assign payload_wrap = payload_reg >= PAYLOAD_LAST;

    always_comb
    begin
        cmd.stream    = stream_reg;
        cmd.mode      = mod_reg[stream_reg];
        cmd.bits      = in_bits;
        cmd.pos       = pos_reg;
        cmd.first     = pos_reg == '0;
        cmd.final_pos = final_pos;
        cmd.pn_neg    = PN_NEG[payload_reg];
        cmd.frame_end = stream_wrap && payload_wrap;
    end

    always_comb
    begin
        pos_next     = pos_reg;
        stream_next  = stream_reg;
        payload_next = payload_reg;
        if (push)
        begin
            if (final_pos)
            begin
                pos_next = '0;
                if (stream_wrap)
                begin
                    stream_next  = '0;
                    payload_next = payload_wrap ? '0 : payload_reg + 1'b1;
                end
                else
                begin
                    stream_next = stream_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            stream_reg  <= '0;
            payload_reg <= '0;
            mod_reg[0]  <= MOD_BPSK;
            mod_reg[1]  <= MOD_BPSK;
            mod_reg[2]  <= MOD_BPSK;
            mod_reg[3]  <= MOD_BPSK;
        end
        else
        begin
            pos_reg     <= pos_next;
            stream_reg  <= stream_next;
            payload_reg <= payload_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MOD_STREAM0: mod_reg[0] <= cfg_data;
                    REG_MOD_STREAM1: mod_reg[1] <= cfg_data;
                    REG_MOD_STREAM2: mod_reg[2] <= cfg_data;
                    REG_MOD_STREAM3: mod_reg[3] <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/osm_queue.sv =====
// Short command queue between the front end and the result generator.
`default_nettype none
module osm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire osm_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output osm_pkg::cmd_t      head
);
    import osm_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/osm_back.sv =====
// Back end: expands each command into pilot and data results, one per cycle unless out_ready stalls it.
`default_nettype none
module osm_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          empty,
    input  wire osm_pkg::cmd_t head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output osm_pkg::result_t   out_result
);
    import osm_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_TAIL  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic       valid_reg;
    result_t    result_reg, result_next;
    logic       load;
    logic       emit_head;
    logic       emit_tail;
    point_t     data_pt;
    point_t     pilot_pt;

    assign load      = !empty && (!valid_reg || out_ready);
    assign emit_head = (phase_reg == PH_START) && head.first;
    assign emit_tail = phase_reg == PH_TAIL;
    assign data_pt   = map_data(head.mode, head.bits);
    assign pilot_pt  = pilot_point(head.stream, head.pn_neg);

    always_comb
    begin
        result_next.stream = head.stream;
        phase_next         = phase_reg;
        pop                = 1'b0;
        if (emit_head)
        begin
            result_next.subcarrier = SC_PILOT_LO;
            result_next.re         = pilot_pt.re;
            result_next.im         = pilot_pt.im;
            result_next.is_pilot   = 1'b1;
            result_next.frame_end  = 1'b0;
            result_next.last       = 1'b0;
            if (load)
            begin
                phase_next = PH_DATA;
            end
        end
        else if (emit_tail)
        begin
            result_next.subcarrier = SC_PILOT_HI;
            result_next.re         = pilot_pt.re;
            result_next.im         = pilot_pt.im;
            result_next.is_pilot   = 1'b1;
            result_next.frame_end  = head.frame_end;
            result_next.last       = 1'b1;
            if (load)
            begin
                phase_next = PH_START;
                pop        = 1'b1;
            end
        end
        else
        begin
            result_next.subcarrier = head.pos + 1'b1;
            result_next.re         = data_pt.re;
            result_next.im         = data_pt.im;
            result_next.is_pilot   = 1'b0;
            result_next.frame_end  = 1'b0;
            result_next.last       = !head.final_pos;
            if (load)
            begin
                if (head.final_pos)
                begin
                    phase_next = PH_TAIL;
                end
                else
                begin
                    phase_next = PH_START;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
`default_nettype wire

// ===== design/ofdm_symbol_mapper_with_pilots_unit.sv =====
// Top level of the OFDM symbol mapper with pilot insertion.
`default_nettype none
// Maps one group of symbol bits per data subcarrier to a Q15 constellation
// point and inserts the stream's pilots at subcarriers 0 and 15, so a
// 14-item symbol of one stream becomes 16 output transfers. Inputs are
// classified by the front end and queued (four entries); the back end
// emits one result per cycle unless m_axis_tready stalls it, from a
// registered output stage. An input yields one output transfer, two on
// the first and last data subcarrier of a stream's symbol, all on one
// port; each passes the queue, then the output register. The user
// must write modulation registers only while idle; no check in the block.
module ofdm_symbol_mapper_with_pilots_unit #(
    parameter int PAYLOAD_SYMBOLS = 16,
    parameter int STREAMS         = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [osm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [osm_pkg::MOD_W-1:0]          cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [3:0] symbol_bits, [7:4] zero
    input  wire logic [7:0]                         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] stream_index, [5:2] subcarrier, [22:6] real_part, [39:23] imag_part
    output logic [39:0]                             m_axis_tdata,
    // [0] is_pilot, [1] frame_end
    output logic [1:0]                              m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import osm_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    head;
    result_t result;

    assign cfg_ready = 1'b1;

    osm_front #(
        .PAYLOAD_SYMBOLS (PAYLOAD_SYMBOLS),
        .STREAMS         (STREAMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_bits   (s_axis_tdata[BITS_W-1:0]),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    osm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    osm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {result.im, result.re, result.subcarrier, result.stream};
    assign m_axis_tuser = {result.frame_end, result.is_pilot};
    assign m_axis_tlast = result.last;

`ifndef SYNTH
    // Frame end only on the closing pilot of a symbol
    a_frame_end_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && result.frame_end |->
            result.is_pilot && result.last && result.subcarrier == SC_PILOT_HI)
        else $error("frame_end on a result other than the closing pilot");

    // Opening pilot is never marked last; a data result of the same item follows it
    a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && result.is_pilot && result.subcarrier == SC_PILOT_LO |->
            !result.last)
        else $error("opening pilot marked as last result");

    // Data never lands on a pilot subcarrier
    a_data_position: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !result.is_pilot |->
            result.subcarrier != SC_PILOT_LO && result.subcarrier != SC_PILOT_HI)
        else $error("data result on a pilot subcarrier");

    // A pop needs a queued command
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire
